>>> hw/rtl/fsa_pkg.sv
package fsa_pkg;

    localparam int LANES              = 4;
    localparam int LANE_IN_W          = 8;
    localparam int LANE_W             = 5;
    localparam int LANE_SHIFT         = LANE_IN_W - LANE_W;
    localparam int PIX_W              = LANES * LANE_IN_W;
    localparam int PACK_W             = LANES * LANE_W;
    localparam int CFG_W              = 18;
    localparam int FRAME_PIXELS_RESET = 76800;

    localparam int MAX_PIXELS_DEF   = 131072;
    localparam int NUM_PLANES_DEF   = 32;
    localparam int PLANE_STRIDE_DEF = 4;

    typedef logic [PACK_W-1:0] t_pack;

    function automatic t_pack pack_lanes(input logic [PIX_W-1:0] px);
        t_pack packed_val;
        packed_val = '0;
        for (int k = 0; k < LANES; k++) begin
            packed_val[k*LANE_W +: LANE_W] = px[k*LANE_IN_W + LANE_SHIFT +: LANE_W];
        end
        return packed_val;
    endfunction

endpackage

>>> hw/rtl/fsa_bank.sv
module fsa_bank #(
    parameter int DEPTH = fsa_pkg::MAX_PIXELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  fsa_pkg::t_pack    i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output fsa_pkg::t_pack    o_rdata
);

    fsa_pkg::t_pack r_mem [DEPTH];
    fsa_pkg::t_pack r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/frame_afterimage_streak.sv
// Afterimage streak filter for a raster pixel stream of 32-bit words with four 8-bit lanes.
// Each pixel is reduced to five bits per lane and written into the frame plane of the current
// frame, and the output pixel is the per-lane sum, saturated at 255, of that pixel position in
// every plane that shares the current plane's residue modulo PLANE_STRIDE. One pixel is taken
// per clock unless the clearing sweep or an output stall holds it off, and passes through
// registered capture, bank read, plane select and sum stages. The planes sit in NUM_PLANES
// separate memory banks read in parallel, and the adder tree over the selected planes sets
// the depth of the last stage. After reset the banks are zeroed, one address of all banks per
// cycle, while input transfers are held off; the frame length register can be written at any
// time. It is clamped to 1..MAX_PIXELS, and each frame's last pixel is flagged with frame_end.
module frame_afterimage_streak #(
    parameter int MAX_PIXELS   = fsa_pkg::MAX_PIXELS_DEF,
    parameter int NUM_PLANES   = fsa_pkg::NUM_PLANES_DEF,
    parameter int PLANE_STRIDE = fsa_pkg::PLANE_STRIDE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fsa_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fsa_pkg::PIX_W-1:0]  i_pixel_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fsa_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                       o_frame_end
);

    localparam int PosW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LenW    = $clog2(MAX_PIXELS + 1);
    localparam int CmpW0   = (PosW + 1 > LenW) ? PosW + 1 : LenW;
    localparam int CmpW    = (CmpW0 > fsa_pkg::CFG_W) ? CmpW0 : fsa_pkg::CFG_W;
    localparam int PlW     = $clog2(NUM_PLANES);
    localparam int ResW    = (PLANE_STRIDE > 1) ? $clog2(PLANE_STRIDE) : 1;
    localparam int LaneMax = (1 << fsa_pkg::LANE_W) - 1;
    localparam int SumW0   = $clog2(NUM_PLANES * LaneMax + 1);
    localparam int SumW    = (SumW0 > fsa_pkg::LANE_IN_W) ? SumW0 : fsa_pkg::LANE_IN_W + 1;
    localparam int LaneSat = (1 << fsa_pkg::LANE_IN_W) - 1;
    localparam int RstLen  = (fsa_pkg::FRAME_PIXELS_RESET > MAX_PIXELS) ?
                             MAX_PIXELS : fsa_pkg::FRAME_PIXELS_RESET;

    logic [LenW-1:0]   r_len;
    logic [PosW-1:0]   r_pos;
    logic [PlW-1:0]    r_plane;
    logic [ResW-1:0]   r_res;
    logic              r_clr;
    logic [PosW-1:0]   r_clr_addr;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [PosW-1:0]   r_s1_pos;
    logic [PlW-1:0]    r_s1_plane, r_s2_plane;
    logic [ResW-1:0]   r_s1_res, r_s2_res;
    fsa_pkg::t_pack    r_s1_pack, r_s2_pack;
    logic              r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    fsa_pkg::t_pack    r_s3_val [NUM_PLANES];
    fsa_pkg::t_pack    n_s3_val [NUM_PLANES];
    fsa_pkg::t_pack    w_rd     [NUM_PLANES];
    logic [fsa_pkg::PIX_W-1:0] r_s4_pix, n_s4_pix;

    logic              w_en1, w_en2, w_en3, w_en4;
    logic              w_in_acc;
    logic [CmpW-1:0]   w_next_pos;
    logic              w_last;
    logic [CmpW-1:0]   w_cfg_ext;
    logic [LenW-1:0]   n_len;
    logic              w_plane_wrap;

    assign w_en4 = !r_v4 || !i_out_stall;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign o_in_stall  = r_clr || !w_en1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_next_pos   = CmpW'(r_pos) + CmpW'(1);
    assign w_last       = w_next_pos >= CmpW'(r_len);
    assign w_plane_wrap = r_plane == PlW'(NUM_PLANES - 1);

    always_comb begin
        w_cfg_ext = CmpW'(i_cfg_data);
        if (w_cfg_ext == '0) begin
            n_len = LenW'(1);
        end else if (w_cfg_ext > CmpW'(MAX_PIXELS)) begin
            n_len = LenW'(MAX_PIXELS);
        end else begin
            n_len = w_cfg_ext[LenW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LenW'(RstLen);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == PosW'(MAX_PIXELS - 1)) begin
                r_clr <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_plane <= '0;
            r_res   <= '0;
        end else if (w_in_acc) begin
            if (w_last) begin
                r_pos   <= '0;
                r_plane <= w_plane_wrap ? '0 : r_plane + PlW'(1);
                r_res   <= (w_plane_wrap || r_res == ResW'(PLANE_STRIDE - 1)) ?
                           '0 : r_res + ResW'(1);
            end else begin
                r_pos <= w_next_pos[PosW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_in_acc;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_pos   <= r_pos;
            r_s1_plane <= r_plane;
            r_s1_res   <= r_res;
            r_s1_pack  <= fsa_pkg::pack_lanes(i_pixel_in);
            r_s1_last  <= w_last;
        end
        if (w_en2) begin
            r_s2_plane <= r_s1_plane;
            r_s2_res   <= r_s1_res;
            r_s2_pack  <= r_s1_pack;
            r_s2_last  <= r_s1_last;
        end
        if (w_en3) begin
            r_s3_val  <= n_s3_val;
            r_s3_last <= r_s2_last;
        end
        if (w_en4) begin
            r_s4_pix  <= n_s4_pix;
            r_s4_last <= r_s3_last;
        end
    end

    for (genvar b = 0; b < NUM_PLANES; b++) begin : g_bank
        logic w_we;

        assign w_we = r_clr || (w_en2 && r_v1 && r_s1_plane == PlW'(b));

        fsa_bank #(
            .DEPTH (MAX_PIXELS),
            .AW    (PosW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (r_clr ? r_clr_addr : r_s1_pos),
            .i_wdata (r_clr ? fsa_pkg::t_pack'(0) : r_s1_pack),
            .i_re    (w_en2),
            .i_raddr (r_s1_pos),
            .o_rdata (w_rd[b])
        );

        // The bank of the current plane is written in the same cycle it is read, so its
        // value comes from the pixel itself.
        assign n_s3_val[b] = (r_s2_res != ResW'(b % PLANE_STRIDE)) ? '0 :
                             (r_s2_plane == PlW'(b)) ? r_s2_pack : w_rd[b];
    end

    always_comb begin
        logic [SumW-1:0] sum;
        n_s4_pix = '0;
        for (int k = 0; k < fsa_pkg::LANES; k++) begin
            sum = '0;
            for (int b = 0; b < NUM_PLANES; b++) begin
                sum = sum + SumW'(r_s3_val[b][k*fsa_pkg::LANE_W +: fsa_pkg::LANE_W]);
            end
            n_s4_pix[k*fsa_pkg::LANE_IN_W +: fsa_pkg::LANE_IN_W] =
                (sum > SumW'(LaneSat)) ? fsa_pkg::LANE_IN_W'(LaneSat) :
                                         sum[fsa_pkg::LANE_IN_W-1:0];
        end
    end

    assign o_out_valid = r_v4;
    assign o_pixel_out = r_s4_pix;
    assign o_frame_end = r_s4_last;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (o_in_stall && !r_v1 && !o_out_valid))
        else $error("pixel transfer during the plane clearing sweep");

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> (r_pos == '0))
        else $error("pixel position did not return to zero after the last pixel");

    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_plane) < NUM_PLANES) && (int'(r_res) < PLANE_STRIDE))
        else $error("frame plane index or its residue out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_pixel_out) && $stable(o_frame_end)))
        else $error("stalled output transfer changed");

endmodule
